@@ hdl/jcfe_pkg.sv @@
// shared types, character codes and helper functions for the json content extractor
// used by every module under hdl; depends on nothing
package jcfe_pkg;

  localparam int BLANK_DEPTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [71:0] KEY_CHOICES = "\"choices\"";
  localparam logic [71:0] KEY_CONTENT = "\"content\"";

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_LOWER_U = 8'h75;
  localparam logic [7:0] CH_QMARK   = 8'h3F;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_R = 8'h72;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_LOWER_F = 8'h66;

  // event codes passed from front to back
  localparam logic [1:0] EV_CHAR    = 2'd0;
  localparam logic [1:0] EV_RESERVE = 2'd1;
  localparam logic [1:0] EV_END     = 2'd2;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FAIL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_OVF   = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic [1:0] n;
    logic       fail;
    logic       last;
  } ev_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic [7:0] esc_map(input logic [7:0] e);
    logic [7:0] r;
    r = e;
    if (e == CH_LOWER_N) r = CH_LF;
    else if (e == CH_LOWER_R) r = CH_CR;
    else if (e == CH_LOWER_T) r = CH_TAB;
    else if (e == CH_LOWER_B) r = CH_BS;
    else if (e == CH_LOWER_F) r = CH_FF;
    return r;
  endfunction

  // msb flags a non-hex byte, low nibble is the digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b10000;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b0, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

@@ hdl/jcfe_front.sv @@
// front end: accepts body bytes, finds the keys, decodes escapes into events
// depends on jcfe_pkg; feeds jcfe_queue
module jcfe_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_body_byte,
  input  logic             in_end_of_body,
  output logic             q_push,
  output jcfe_pkg::ev_t    q_wdata,
  input  logic             q_full
);

  localparam logic [3:0] PH_CHOICES = 4'd0;
  localparam logic [3:0] PH_CONTENT = 4'd1;
  localparam logic [3:0] PH_COLON   = 4'd2;
  localparam logic [3:0] PH_SKIPWS  = 4'd3;
  localparam logic [3:0] PH_STRING  = 4'd4;
  localparam logic [3:0] PH_BACKSL  = 4'd5;
  localparam logic [3:0] PH_HEX     = 4'd6;
  localparam logic [3:0] PH_DONE    = 4'd7;
  localparam logic [3:0] PH_FAIL    = 4'd8;

  localparam logic FR_RUN   = 1'b0;
  localparam logic FR_FLUSH = 1'b1;

  logic        fr_state_r, fr_state_nxt;
  logic [3:0]  phase_r, phase_nxt;
  logic [63:0] window_r, window_nxt;
  logic [15:0] hex_val_r, hex_val_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic        hex_bad_r, hex_bad_nxt;
  logic [1:0]  flush_k_r, flush_k_nxt;
  logic        fail_r, fail_nxt;
  logic [7:0]  held_r [3];
  logic [7:0]  held_nxt [3];

  logic          accept;
  logic [7:0]    c;
  logic [4:0]    hd;
  logic [2:0]    hex_cnt_inc;
  logic [15:0]   hex_val_step;
  logic          hex_bad_step;
  logic [3:0]    st_phase;
  logic          st_ev_valid;
  jcfe_pkg::ev_t st_ev;
  logic [15:0]   st_hex_val;
  logic [1:0]    st_hex_cnt;
  logic          st_hex_bad;
  logic          st_fail;
  logic          fl_push;
  logic          fl_adv;
  jcfe_pkg::ev_t fl_ev;

  assign in_stall = (fr_state_r != FR_RUN) || q_full;
  assign accept   = in_valid && !in_stall;
  assign c        = in_body_byte;

  // one byte through the phase machine
  always_comb begin
    hd           = jcfe_pkg::hex_digit(c);
    hex_cnt_inc  = {1'b0, hex_cnt_r} + 3'd1;
    hex_val_step = {hex_val_r[11:0], hd[3:0]};
    hex_bad_step = hex_bad_r | hd[4];
    st_phase     = phase_r;
    st_ev_valid  = 1'b0;
    st_ev        = '{op: jcfe_pkg::EV_CHAR, data: c, n: 2'd0, fail: 1'b0,
                     last: !in_end_of_body};
    st_hex_val   = hex_val_r;
    st_hex_cnt   = hex_cnt_r;
    st_hex_bad   = hex_bad_r;
    unique case (phase_r)
      PH_CHOICES: begin
        if ({window_r, c} == jcfe_pkg::KEY_CHOICES) st_phase = PH_CONTENT;
      end
      PH_CONTENT: begin
        if ({window_r, c} == jcfe_pkg::KEY_CONTENT) st_phase = PH_COLON;
      end
      PH_COLON: begin
        if (c == jcfe_pkg::CH_COLON) st_phase = PH_SKIPWS;
      end
      PH_SKIPWS: begin
        if (!jcfe_pkg::is_blank(c))
          st_phase = (c == jcfe_pkg::CH_QUOTE) ? PH_STRING : PH_FAIL;
      end
      PH_STRING: begin
        priority if (c == jcfe_pkg::CH_QUOTE) st_phase = PH_DONE;
        else if (c == jcfe_pkg::CH_BSLASH) st_phase = PH_BACKSL;
        else st_ev_valid = 1'b1;
      end
      PH_BACKSL: begin
        if (c == jcfe_pkg::CH_LOWER_U) begin
          st_phase   = PH_HEX;
          st_hex_val = 16'd0;
          st_hex_cnt = 2'd0;
          st_hex_bad = 1'b0;
        end else begin
          st_ev_valid = 1'b1;
          st_ev.data  = jcfe_pkg::esc_map(c);
          st_phase    = PH_STRING;
        end
      end
      PH_HEX: begin
        st_hex_val = hex_val_step;
        st_hex_bad = hex_bad_step;
        if (hex_cnt_inc == 3'd4) begin
          st_hex_cnt = 2'd0;
          st_phase   = PH_STRING;
          if (!hex_bad_step) begin
            st_ev_valid = 1'b1;
            st_ev.data  = (hex_val_step[15:7] == 9'd0) ? hex_val_step[7:0]
                                                       : jcfe_pkg::CH_QMARK;
          end
        end else begin
          st_hex_cnt  = hex_cnt_inc[1:0];
          st_ev_valid = 1'b1;
          st_ev.op    = jcfe_pkg::EV_RESERVE;
          st_ev.n     = hex_cnt_inc[1:0];
        end
      end
      default: ;
    endcase
    st_fail = !((st_phase == PH_STRING) || (st_phase == PH_BACKSL) ||
                (st_phase == PH_HEX) || (st_phase == PH_DONE));
  end

  // held bytes replayed as text after a cut-short escape, then the end event
  always_comb begin
    fl_push = 1'b0;
    fl_adv  = 1'b0;
    fl_ev   = '{op: jcfe_pkg::EV_CHAR, data: held_r[0], n: 2'd0, fail: 1'b0,
                last: 1'b0};
    if (flush_k_r == 2'd0) begin
      fl_push     = 1'b1;
      fl_ev.op    = jcfe_pkg::EV_END;
      fl_ev.data  = 8'd0;
      fl_ev.fail  = fail_r;
      fl_ev.last  = 1'b1;
    end else if (held_r[0] == jcfe_pkg::CH_QUOTE) begin
      fl_adv = 1'b1;
    end else if (held_r[0] == jcfe_pkg::CH_BSLASH && flush_k_r >= 2'd2) begin
      fl_push    = (held_r[1] != jcfe_pkg::CH_LOWER_U);
      fl_ev.data = jcfe_pkg::esc_map(held_r[1]);
      fl_adv     = !fl_push || !q_full;
    end else begin
      fl_push = 1'b1;
      fl_adv  = !q_full;
    end
  end

  always_comb begin
    fr_state_nxt = fr_state_r;
    phase_nxt    = phase_r;
    window_nxt   = window_r;
    hex_val_nxt  = hex_val_r;
    hex_cnt_nxt  = hex_cnt_r;
    hex_bad_nxt  = hex_bad_r;
    flush_k_nxt  = flush_k_r;
    fail_nxt     = fail_r;
    held_nxt     = held_r;
    q_push       = 1'b0;
    q_wdata      = st_ev;
    unique case (fr_state_r)
      FR_RUN: begin
        if (accept) begin
          q_push      = st_ev_valid;
          phase_nxt   = st_phase;
          hex_val_nxt = st_hex_val;
          hex_cnt_nxt = st_hex_cnt;
          hex_bad_nxt = st_hex_bad;
          if (phase_r == PH_CHOICES || phase_r == PH_CONTENT)
            window_nxt = {window_r[55:0], c};
          if (phase_r == PH_HEX && hex_cnt_r != 2'd3)
            held_nxt[hex_cnt_r] = c;
          if (in_end_of_body) begin
            phase_nxt    = PH_CHOICES;
            window_nxt   = 64'd0;
            hex_val_nxt  = 16'd0;
            hex_cnt_nxt  = 2'd0;
            hex_bad_nxt  = 1'b0;
            fail_nxt     = st_fail;
            fr_state_nxt = FR_FLUSH;
            flush_k_nxt  = 2'd0;
            if (st_phase == PH_BACKSL) begin
              held_nxt[0] = jcfe_pkg::CH_BSLASH;
              flush_k_nxt = 2'd1;
            end else if (st_phase == PH_HEX) begin
              flush_k_nxt = st_hex_cnt;
            end
          end
        end
      end
      FR_FLUSH: begin
        q_push  = fl_push && !q_full;
        q_wdata = fl_ev;
        if (flush_k_r == 2'd0) begin
          if (!q_full) fr_state_nxt = FR_RUN;
        end else if (held_r[0] == jcfe_pkg::CH_QUOTE) begin
          flush_k_nxt = 2'd0;
        end else if (held_r[0] == jcfe_pkg::CH_BSLASH && flush_k_r >= 2'd2) begin
          if (fl_adv) begin
            held_nxt[0] = held_r[2];
            flush_k_nxt = flush_k_r - 2'd2;
          end
        end else if (fl_adv) begin
          held_nxt[0] = held_r[1];
          held_nxt[1] = held_r[2];
          flush_k_nxt = flush_k_r - 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_state_r <= FR_RUN;
      phase_r    <= PH_CHOICES;
      window_r   <= 64'd0;
      hex_val_r  <= 16'd0;
      hex_cnt_r  <= 2'd0;
      hex_bad_r  <= 1'b0;
      flush_k_r  <= 2'd0;
      fail_r     <= 1'b0;
    end else begin
      fr_state_r <= fr_state_nxt;
      phase_r    <= phase_nxt;
      window_r   <= window_nxt;
      hex_val_r  <= hex_val_nxt;
      hex_cnt_r  <= hex_cnt_nxt;
      hex_bad_r  <= hex_bad_nxt;
      flush_k_r  <= flush_k_nxt;
      fail_r     <= fail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule

@@ hdl/jcfe_queue.sv @@
// short event queue between front and back end
// depends on jcfe_pkg for the event type and depth
module jcfe_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jcfe_pkg::ev_t wdata,
  output logic          full,
  output logic          valid,
  output jcfe_pkg::ev_t rdata,
  input  logic          pop
);

  localparam int QP_W = (jcfe_pkg::QUEUE_DEPTH > 1) ? $clog2(jcfe_pkg::QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(jcfe_pkg::QUEUE_DEPTH + 1);
  localparam logic [QP_W-1:0] QP_LAST = QP_W'(jcfe_pkg::QUEUE_DEPTH - 1);
  localparam logic [QC_W-1:0] QC_FULL = QC_W'(jcfe_pkg::QUEUE_DEPTH);

  jcfe_pkg::ev_t   slot_r [jcfe_pkg::QUEUE_DEPTH];
  logic [QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QC_W-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == QC_FULL);
  assign valid   = (cnt_r != '0);
  assign rdata   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == QP_LAST) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == QP_LAST) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= wdata;
  end

endmodule

@@ hdl/jcfe_back.sv @@
// back end: trims blanks through the pending-blank store and drives the result register
// depends on jcfe_pkg; takes events from jcfe_queue
module jcfe_back #(
  parameter int BLANK_DEPTH = jcfe_pkg::BLANK_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  jcfe_pkg::ev_t q_rdata,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_kind,
  output logic [7:0]    out_data_byte,
  output logic [1:0]    out_status,
  output logic          out_last
);

  localparam int PTR_W = (BLANK_DEPTH > 1) ? $clog2(BLANK_DEPTH) : 1;
  localparam int CNT_W = $clog2(BLANK_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(BLANK_DEPTH);
  localparam logic [CNT_W:0]   SUM_LIMIT = (CNT_W + 1)'(BLANK_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(BLANK_DEPTH - 1);

  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_RD   = 2'd1;
  localparam logic [1:0] BK_POP  = 2'd2;

  logic [1:0]       bk_state_r, bk_state_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             started_r, started_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r;
  logic             out_kind_r;
  logic [7:0]       out_data_r;
  logic [1:0]       out_status_r;
  logic             out_last_r;
  logic [7:0]       mem_r [BLANK_DEPTH];
  logic [7:0]       rd_data_r;

  jcfe_pkg::ev_t    ev;
  logic             out_free;
  logic             ev_blank;
  logic [CNT_W-1:0] cnt_dec;
  logic             res_over;
  logic             res_over_dec;
  logic [PTR_W-1:0] head_inc, tail_inc;
  logic [1:0]       status_code;
  logic             mem_we;
  logic             emit;
  logic             emit_kind;
  logic [7:0]       emit_data;
  logic [1:0]       emit_status;
  logic             emit_last;
  logic             end_take;

  assign ev           = q_rdata;
  assign out_free     = !out_valid_r || !out_stall;
  assign ev_blank     = jcfe_pkg::is_blank(ev.data);
  assign cnt_dec      = cnt_r - 1'b1;
  assign res_over     = (cnt_r != '0) &&
                        (({1'b0, cnt_r} + (CNT_W + 1)'(ev.n)) > SUM_LIMIT);
  assign res_over_dec = (cnt_dec != '0) &&
                        (({1'b0, cnt_dec} + (CNT_W + 1)'(ev.n)) > SUM_LIMIT);
  assign head_inc     = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
  assign tail_inc     = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
  assign end_take     = (bk_state_r == BK_IDLE) && q_valid &&
                        (ev.op == jcfe_pkg::EV_END) && out_free;

  always_comb begin
    priority if (ev.fail) status_code = jcfe_pkg::ST_FAIL;
    else if (!started_r) status_code = jcfe_pkg::ST_EMPTY;
    else if (ovf_r) status_code = jcfe_pkg::ST_OVF;
    else status_code = jcfe_pkg::ST_OK;
  end

  always_comb begin
    bk_state_nxt = bk_state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cnt_nxt      = cnt_r;
    started_nxt  = started_r;
    ovf_nxt      = ovf_r;
    q_pop        = 1'b0;
    mem_we       = 1'b0;
    emit         = 1'b0;
    emit_kind    = jcfe_pkg::KIND_BYTE;
    emit_data    = ev.data;
    emit_status  = jcfe_pkg::ST_OK;
    emit_last    = ev.last;
    unique case (bk_state_r)
      BK_IDLE: begin
        if (q_valid) begin
          case (ev.op)
            jcfe_pkg::EV_CHAR: begin
              if (ev_blank) begin
                priority if (!started_r) begin
                  q_pop = 1'b1;
                end else if (cnt_r == CNT_FULL) begin
                  bk_state_nxt = BK_RD;
                end else begin
                  mem_we   = 1'b1;
                  tail_nxt = tail_inc;
                  cnt_nxt  = cnt_r + 1'b1;
                  q_pop    = 1'b1;
                end
              end else if (cnt_r != '0) begin
                bk_state_nxt = BK_RD;
              end else if (out_free) begin
                emit        = 1'b1;
                started_nxt = 1'b1;
                q_pop       = 1'b1;
              end
            end
            jcfe_pkg::EV_RESERVE: begin
              if (res_over) bk_state_nxt = BK_RD;
              else q_pop = 1'b1;
            end
            jcfe_pkg::EV_END: begin
              if (out_free) begin
                emit        = 1'b1;
                emit_kind   = jcfe_pkg::KIND_STATUS;
                emit_data   = 8'd0;
                emit_status = status_code;
                emit_last   = 1'b1;
                started_nxt = 1'b0;
                ovf_nxt     = 1'b0;
                cnt_nxt     = '0;
                head_nxt    = '0;
                tail_nxt    = '0;
                q_pop       = 1'b1;
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      BK_RD: begin
        bk_state_nxt = BK_POP;
      end
      BK_POP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = rd_data_r;
          head_nxt  = head_inc;
          cnt_nxt   = cnt_dec;
          priority if (ev.op == jcfe_pkg::EV_CHAR && ev_blank) begin
            ovf_nxt      = 1'b1;
            mem_we       = 1'b1;
            tail_nxt     = tail_inc;
            cnt_nxt      = cnt_r;
            q_pop        = 1'b1;
            bk_state_nxt = BK_IDLE;
          end else if (ev.op == jcfe_pkg::EV_CHAR) begin
            emit_last    = 1'b0;
            bk_state_nxt = (cnt_dec != '0) ? BK_RD : BK_IDLE;
          end else if (ev.op == jcfe_pkg::EV_RESERVE) begin
            ovf_nxt   = 1'b1;
            emit_last = ev.last && !res_over_dec;
            if (res_over_dec) begin
              bk_state_nxt = BK_RD;
            end else begin
              q_pop        = 1'b1;
              bk_state_nxt = BK_IDLE;
            end
          end else begin
            emit_last    = 1'b0;
            bk_state_nxt = BK_IDLE;
          end
        end
      end
      default: bk_state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bk_state_r  <= BK_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      started_r   <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bk_state_r <= bk_state_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      cnt_r      <= cnt_nxt;
      started_r  <= started_nxt;
      ovf_r      <= ovf_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r   <= emit_kind;
      out_data_r   <= emit_data;
      out_status_r <= emit_status;
      out_last_r   <= emit_last;
    end
  end

  // pending-blank store
  always_ff @(posedge clk) begin
    if (mem_we) mem_r[tail_r] <= ev.data;
    rd_data_r <= mem_r[head_r];
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_data_byte = out_data_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

  a_rd_then_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_state_r == BK_RD) |=> (bk_state_r == BK_POP))
    else $error("store read not followed by release");

  a_pop_has_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_state_r == BK_POP) |-> (cnt_r != '0))
    else $error("release from an empty blank store");

  a_pop_word_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_state_r == BK_POP && out_free) |=>
      (out_valid_r && out_kind_r == jcfe_pkg::KIND_BYTE &&
       jcfe_pkg::is_blank(out_data_r)))
    else $error("released word is not a blank");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    end_take |=> (cnt_r == '0 && !started_r && !ovf_r))
    else $error("status word did not clear body state");

endmodule

@@ hdl/json_content_field_extractor.sv @@
// Streams the decoded, trimmed string value of the first "content" key after
// the first "choices" key of a JSON body, then one status word per body.
// Input channel in_*: one body byte per word, in_end_of_body on the final byte.
// Output channel out_*: out_kind 0 carries a content byte, out_kind 1 the
// status; out_last marks the final result word caused by an input word.
// Both channels move a word on a clock edge with valid high and stall low.
// Throughput: one body byte per cycle while the four-word event queue has
// room and no end-of-body flush is under way. Each held blank is released
// through state BK_RD, the registered read of the blank store, then BK_POP;
// end of body holds in_stall while held escape bytes and the status word are
// queued. With the queue and result register empty, a content byte is written
// to a queue slot as its input word is accepted, then to the result register.
// Reset (rst_n low, synchronous) clears all control state; the blank store
// needs no clearing pass. A stalled result holds; the queue then fills and
// in_stall rises until the receiver takes words again.
// depends on jcfe_pkg, jcfe_front, jcfe_queue, jcfe_back
module json_content_field_extractor #(
  parameter int BLANK_DEPTH = jcfe_pkg::BLANK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_body_byte,
  input  logic       in_end_of_body,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_data_byte,
  output logic [1:0] out_status,
  output logic       out_last
);

  logic          q_push;
  jcfe_pkg::ev_t q_wdata;
  logic          q_full;
  logic          q_valid;
  jcfe_pkg::ev_t q_rdata;
  logic          q_pop;

  jcfe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_body_byte   (in_body_byte),
    .in_end_of_body (in_end_of_body),
    .q_push         (q_push),
    .q_wdata        (q_wdata),
    .q_full         (q_full)
  );

  jcfe_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .valid (q_valid),
    .rdata (q_rdata),
    .pop   (q_pop)
  );

  jcfe_back #(
    .BLANK_DEPTH (BLANK_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_data_byte (out_data_byte),
    .out_status    (out_status),
    .out_last      (out_last)
  );

endmodule
